// ===== rtl/distinct_partition_counter_core_assert.svh =====
// Assertion macros for the partition counter core.
`ifndef DISTINCT_PARTITION_COUNTER_CORE_ASSERT_SVH
`define DISTINCT_PARTITION_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define DPC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("dpc assertion failed");

// Next-cycle implication, disabled in reset.
`define DPC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("dpc assertion failed");

`endif

// ===== rtl/dpc_pkg.sv =====
`default_nettype none
package dpc_pkg;

    localparam int MAX_TOTAL_DEF = 128;
    localparam int IN_W          = 8;
    localparam int WAYS_W        = 24;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic update;
        logic next_part;
        logic read_final;
        logic emit_zero;
        logic emit_read;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic over_range;
        logic clear_last;
        logic entry_last;
        logic part_last;
        logic no_parts;
    } sts_t;

endpackage
`default_nettype wire

// ===== rtl/distinct_partition_counter_core.sv =====
// Counts the partitions of total into distinct positive parts, all below
// part_bound, saturating at 2^24-1. A word is taken when start is high while
// busy is low; exactly one result follows, shown on ways for one cycle with
// done high. The receiver cannot stall, so ways must be captured in that
// cycle. The table memory does one read-modify-write per cycle during each
// downward pass, through its single write port, pausing between passes.
// A total above MAX_TOTAL gives 0 without any table pass. A clearing pass
// first sets entry 0 to 1 and entries 1 to total to 0 for each item.
`default_nettype none
module distinct_partition_counter_core
    import dpc_pkg::*;
#(
    parameter int MAX_TOTAL = MAX_TOTAL_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [IN_W-1:0]   total,
    input  wire logic [IN_W-1:0]   part_bound,
    output logic                   done,
    output logic [WAYS_W-1:0]      ways
);

    cmd_t cmd;
    sts_t sts;
    logic ctrl_busy;

    // Sequencer: clear sweep, one downward pass per part, final read.
    dpc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (ctrl_busy)
    );

    // Table memory, counters and the saturating adder.
    dpc_datapath #(
        .MAX_TOTAL (MAX_TOTAL)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .total      (total),
        .part_bound (part_bound),
        .sts        (sts),
        .done       (done),
        .ways       (ways)
    );

    assign busy = ctrl_busy;

endmodule
`default_nettype wire

// ===== rtl/dpc_ctrl.sv =====
`default_nettype none
module dpc_ctrl
    import dpc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire sts_t sts,
    output cmd_t      cmd,
    output logic      busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                if (sts.over_range)
                begin
                    cmd.emit_zero = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.clear = 1'b1;
                    if (sts.clear_last)
                    begin
                        state_next = sts.no_parts ? S_READ : S_UPDATE;
                    end
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                if (sts.entry_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last write of the pass lands here
                if (sts.part_last)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    cmd.next_part = 1'b1;
                    state_next    = S_UPDATE;
                end
            end
            S_READ:
            begin
                cmd.read_final = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit_read = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/dpc_datapath.sv =====
`default_nettype none
module dpc_datapath
    import dpc_pkg::*;
#(
    parameter int MAX_TOTAL = MAX_TOTAL_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    input  wire logic [IN_W-1:0]   total,
    input  wire logic [IN_W-1:0]   part_bound,
    output sts_t                   sts,
    output logic                   done,
    output logic [WAYS_W-1:0]      ways
);

    localparam int DEPTH = MAX_TOTAL + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = (IW > IN_W) ? IW : IN_W;
    localparam int OW    = CW + 1;
    localparam logic [WAYS_W-1:0] WAYS_MAX = {WAYS_W{1'b1}};

    logic [WAYS_W-1:0] mem [DEPTH];

    logic [IW-1:0]     total_reg;
    logic [IW-1:0]     last_reg;
    logic              over_reg;
    logic [IW-1:0]     part_reg;
    logic [IW-1:0]     entry_reg;
    logic              pipe_vld_reg;
    logic [IW-1:0]     pipe_addr_reg;
    logic [WAYS_W-1:0] rd_a_reg;
    logic [WAYS_W-1:0] rd_b_reg;
    logic              done_reg;
    logic [WAYS_W-1:0] ways_reg;

    logic [IN_W-1:0]   lp8;
    logic [IN_W-1:0]   lp8_clip;
    logic [CW-1:0]     total_w;
    logic [CW-1:0]     last_w;
    logic              over_in;
    logic [IW-1:0]     rd_a_addr;
    logic [IW-1:0]     rd_b_addr;
    logic [WAYS_W:0]   sum;
    logic [WAYS_W-1:0] sum_sat;
    logic [WAYS_W-1:0] clear_val;

    // last allowed part, clipped to the total
    assign lp8      = (part_bound == '0) ? '0 : part_bound - IN_W'(1);
    assign lp8_clip = (lp8 > total) ? total : lp8;
    assign total_w  = CW'(total);
    assign last_w   = CW'(lp8_clip);
    assign over_in  = OW'(total) > OW'(MAX_TOTAL);

    assign rd_a_addr = cmd.read_final ? total_reg : entry_reg;
    assign rd_b_addr = entry_reg - part_reg;

    assign sum       = {1'b0, rd_a_reg} + {1'b0, rd_b_reg};
    assign sum_sat   = sum[WAYS_W] ? WAYS_MAX : sum[WAYS_W-1:0];
    assign clear_val = (entry_reg == '0) ? WAYS_W'(1) : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mem[entry_reg] <= clear_val;
        end
        else if (pipe_vld_reg)
        begin
            mem[pipe_addr_reg] <= sum_sat;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg     <= '0;
            entry_reg    <= '0;
            pipe_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            pipe_vld_reg <= cmd.update;
            done_reg     <= cmd.emit_zero | cmd.emit_read;
            if (cmd.load)
            begin
                entry_reg <= '0;
            end
            else if (cmd.clear)
            begin
                if (entry_reg == total_reg)
                begin
                    entry_reg <= total_reg;
                    part_reg  <= IW'(1);
                end
                else
                begin
                    entry_reg <= entry_reg + IW'(1);
                end
            end
            else if (cmd.update)
            begin
                entry_reg <= entry_reg - IW'(1);
            end
            else if (cmd.next_part)
            begin
                part_reg  <= part_reg + IW'(1);
                entry_reg <= total_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            total_reg <= total_w[IW-1:0];
            last_reg  <= last_w[IW-1:0];
            over_reg  <= over_in;
        end
        if (cmd.update)
        begin
            pipe_addr_reg <= entry_reg;
        end
        if (cmd.emit_zero)
        begin
            ways_reg <= '0;
        end
        else if (cmd.emit_read)
        begin
            ways_reg <= rd_a_reg;
        end
    end

    assign sts.over_range = over_reg;
    assign sts.clear_last = (entry_reg == total_reg);
    assign sts.entry_last = (entry_reg == part_reg);
    assign sts.part_last  = (part_reg == last_reg);
    assign sts.no_parts   = (last_reg == '0);

    assign done = done_reg;
    assign ways = ways_reg;

endmodule
`default_nettype wire

// ===== rtl/dpc_checker.sv =====
`default_nettype none
`include "distinct_partition_counter_core_assert.svh"
module dpc_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    // an accepted word keeps the block busy until its result
    `DPC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // result strobe lasts one cycle
    `DPC_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    // result appears as the block goes idle
    `DPC_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    // the block only leaves busy by delivering a result
    `DPC_ASSERT_NOW(a_fell_done, clk, rst_n, $fell(busy), done)

endmodule

bind distinct_partition_counter_core dpc_checker u_dpc_checker (.*);
`default_nettype wire
